### hw/rtl/spk_pkg.sv
// Shared types, constants and rotate helpers for the SPECK-128 CTR byte stream.
`default_nettype none
package spk_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = 2;
  localparam int unsigned QCNT_W  = 3;

  // Register select values of paddr[3], the only address bit decoded
  localparam logic REG_KEY_LOW  = 1'b0;
  localparam logic REG_KEY_HIGH = 1'b1;

  // One queued byte with its block coordinates
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              eom;
    logic [POS_W-1:0]  pos;
    logic [IDX_W-1:0]  idx;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic running;
    logic pop;
  } bk_stat_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } bk_state_e;

  function automatic logic [WORD_W-1:0] ror8(input logic [WORD_W-1:0] v);
    return {v[7:0], v[WORD_W-1:8]};
  endfunction

  function automatic logic [WORD_W-1:0] rol3(input logic [WORD_W-1:0] v);
    return {v[WORD_W-4:0], v[WORD_W-1:WORD_W-3]};
  endfunction

endpackage
`default_nettype wire

### hw/rtl/spk_front.sv
// Input side: takes bytes and tags them with byte position and block index.
`default_nettype none
module spk_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [7:0]     s_axis_tdata_i,
  input  wire logic           s_axis_tlast_i,
  input  wire logic           s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  wire spk_pkg::q_stat_t q_stat_i,
  output logic                push_o,
  output spk_pkg::item_t      item_o
);
  import spk_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d;
  logic [IDX_W-1:0] idx_q, idx_d;

  assign s_axis_tready_o = !q_stat_i.full;
  assign push_o          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    item_o.data = s_axis_tdata_i;
    item_o.eom  = s_axis_tlast_i;
    item_o.pos  = pos_q;
    item_o.idx  = idx_q;
  end

  always_comb begin
    pos_d = pos_q;
    idx_d = idx_q;
    if (push_o) begin
      if (s_axis_tlast_i) begin
        pos_d = '0;
        idx_d = '0;
      end else begin
        pos_d = pos_q + POS_W'(1);
        // wrap of the position starts the next counter block
        if (pos_q == {POS_W{1'b1}}) begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      idx_q <= '0;
    end else begin
      pos_q <= pos_d;
      idx_q <= idx_d;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/spk_fifo.sv
// Short word queue between the input side and the cipher back end.
`default_nettype none
module spk_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire spk_pkg::item_t   item_i,
  input  wire logic             pop_i,
  output spk_pkg::item_t        head_o,
  output spk_pkg::q_stat_t      stat_o
);
  import spk_pkg::*;

  item_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/spk_back.sv
// Cipher back end: iterated SPECK round with on-the-fly key schedule, XOR, output register.
`default_nettype none
module spk_back #(
  parameter int unsigned ROUND_COUNT = 32
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [63:0]    key_low_i,
  input  wire logic [63:0]    key_high_i,
  input  wire spk_pkg::item_t head_i,
  input  wire spk_pkg::q_stat_t q_stat_i,
  output spk_pkg::bk_stat_t   stat_o,
  output logic [7:0]          m_axis_tdata_o,
  output logic                m_axis_tlast_o,
  output logic                m_axis_tvalid_o,
  input  wire logic           m_axis_tready_i
);
  import spk_pkg::*;

  localparam int unsigned RndW = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
  localparam logic [RndW-1:0] RND_LAST = RndW'(ROUND_COUNT - 1);

  bk_state_e         st_q, st_d;
  logic [WORD_W-1:0] x_q, y_q, k_q, l_q;
  logic [WORD_W-1:0] x_n, y_n, k_n, l_n;
  logic [RndW-1:0]   rnd_q;
  logic [2*WORD_W-1:0] ks_q;
  logic              blk_done_q;
  logic              out_valid_q;
  logic [BYTE_W-1:0] out_data_q;
  logic              out_last_q;

  logic out_free, head_needs_blk, start, emit, last_rnd;

  assign out_free       = !out_valid_q || m_axis_tready_i;
  assign head_needs_blk = (head_i.pos == '0) && !blk_done_q;
  assign last_rnd       = (rnd_q == RND_LAST);

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (!q_stat_i.empty && head_needs_blk) st_d = ST_RUN;
      ST_RUN:  if (last_rnd) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    start = 1'b0;
    emit  = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        start = !q_stat_i.empty && head_needs_blk;
        emit  = !q_stat_i.empty && !head_needs_blk && out_free;
      end
      ST_RUN: begin
        start = 1'b0;
        emit  = 1'b0;
      end
      default: begin
        start = 1'b0;
        emit  = 1'b0;
      end
    endcase
  end

  assign stat_o.running = (st_q == ST_RUN);
  assign stat_o.pop     = emit;

  // one round of the cipher and of the key schedule side by side
  always_comb begin
    x_n = (ror8(x_q) + y_q) ^ k_q;
    y_n = rol3(y_q) ^ x_n;
    l_n = (ror8(l_q) + k_q) ^ {{(WORD_W-RndW){1'b0}}, rnd_q};
    k_n = rol3(k_q) ^ l_n;
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      x_q   <= {head_i.idx, {(WORD_W-IDX_W){1'b0}}};
      y_q   <= '0;
      k_q   <= key_low_i;
      l_q   <= key_high_i;
      rnd_q <= '0;
    end else if (st_q == ST_RUN) begin
      x_q   <= x_n;
      y_q   <= y_n;
      k_q   <= k_n;
      l_q   <= l_n;
      rnd_q <= rnd_q + RndW'(1);
    end
    if (st_q == ST_RUN && last_rnd) begin
      ks_q <= {x_n, y_n};
    end
    if (emit) begin
      out_data_q <= head_i.data ^ ks_q[{head_i.pos, 3'b000} +: BYTE_W];
      out_last_q <= head_i.eom;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      blk_done_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == ST_RUN && last_rnd) begin
        blk_done_q <= 1'b1;
      end else if (emit) begin
        blk_done_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule
`default_nettype wire

### hw/rtl/speck128_ctr_keystream_xor_top.sv
// Top level of the SPECK-128/128 counter-mode keystream XOR byte stream.
//
//  channel   | direction | word                         | handshake
//  ----------+-----------+------------------------------+-------------------------
//  s_axis    | in        | tdata[7:0] data_in,          | tvalid & tready
//            |           | tlast end_of_message         |
//  m_axis    | out       | tdata[7:0] data_out,         | tvalid & tready
//            |           | tlast final_byte             |
//  apb       | cfg       | 0x0 key_low, 0x8 key_high    | psel & penable & pwrite
//
// A byte at block position 0 needs a load step and ROUND_COUNT rounds in the one
// iterated round unit before it is presented; the other 15 bytes follow one per
// cycle while the queue holds them and the output is not stalled.
// Key writes take effect on the next block; keys are scheduled alongside rounds.
// Reset (rst_ni low, async) clears keys, queue, counters and output valid.
// A four-word queue takes input during rounds or output stalls until it fills.
`default_nettype none
module speck128_ctr_keystream_xor_top #(
  parameter int unsigned ROUND_COUNT = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // [7:0] data_in
  input  wire logic [7:0]  s_axis_tdata_i,
  input  wire logic        s_axis_tlast_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [7:0] data_out
  output logic [7:0]       m_axis_tdata_o,
  output logic             m_axis_tlast_o,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);
  import spk_pkg::*;

  logic [63:0] key_low_q, key_high_q;
  logic        cfg_wr;
  logic        push;
  item_t       item, head;
  q_stat_t     q_stat;
  bk_stat_t    bk_stat;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[3])
      REG_KEY_LOW:  prdata = key_low_q;
      REG_KEY_HIGH: prdata = key_high_q;
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
    end else if (cfg_wr) begin
      if (paddr[3] == REG_KEY_LOW) begin
        key_low_q <= pwdata;
      end else begin
        key_high_q <= pwdata;
      end
    end
  end

  // ---------------- front: tag and enqueue ----------------
  spk_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .q_stat_i       (q_stat),
    .push_o         (push),
    .item_o         (item)
  );

  spk_fifo u_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .item_i(item),
    .pop_i (bk_stat.pop),
    .head_o(head),
    .stat_o(q_stat)
  );

  // ---------------- back: rounds, XOR, output register ----------------
  spk_back #(
    .ROUND_COUNT(ROUND_COUNT)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .key_low_i      (key_low_q),
    .key_high_i     (key_high_q),
    .head_i         (head),
    .q_stat_i       (q_stat),
    .stat_o         (bk_stat),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i)
  );

`ifndef NO_ASSERTIONS
  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.pop |-> !q_stat.empty) else $error("pop from empty queue");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full) else $error("push into full queue");

  a_no_emit_in_rounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.running |-> !bk_stat.pop) else $error("byte emitted during rounds");

  a_pop_gives_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.pop |=> m_axis_tvalid_o) else $error("popped word not presented");
`endif

endmodule
`default_nettype wire

### sim/speck128_ctr_keystream_xor_checker.sv
// Checker for the SPECK-128 CTR byte stream: predicts each output word and compares it.
`timescale 1ns / 100ps
`default_nettype none
module speck128_ctr_keystream_xor_checker #(
  parameter int unsigned ROUNDS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // [7:0] data_in
  input  wire logic [7:0]  s_tdata_i,
  input  wire logic        s_tlast_i,
  input  wire logic        s_tvalid_i,
  input  wire logic        s_tready_i,
  // [7:0] data_out
  input  wire logic [7:0]  m_tdata_i,
  input  wire logic        m_tlast_i,
  input  wire logic        m_tvalid_i,
  input  wire logic        m_tready_i,
  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic [3:0]  paddr_i,
  input  wire logic [63:0] pwdata_i,
  input  wire logic        pready_i,
  output int               fail_count_o,
  output int               pending_o
);
  import spk_pkg::*;

  localparam int MAX_SHOWN = 100;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } out_word_t;

  logic [WORD_W-1:0] key_lo;
  logic [WORD_W-1:0] key_hi;
  logic [WORD_W-1:0] round_keys [32];
  logic              keys_stale;
  logic [WORD_W-1:0] ks_x;
  logic [WORD_W-1:0] ks_y;
  logic [POS_W-1:0]  byte_pos;
  logic [IDX_W-1:0]  blk_idx;
  out_word_t         want_q [$];
  int                shown;

  function automatic logic [WORD_W-1:0] rotr_byte(input logic [WORD_W-1:0] v);
    return (v >> 8) | (v << (WORD_W - 8));
  endfunction

  function automatic logic [WORD_W-1:0] rotl_three(input logic [WORD_W-1:0] v);
    return (v << 3) | (v >> (WORD_W - 3));
  endfunction

  // Standard SPECK key schedule, k0 = key_lo, l0 = key_hi
  function automatic void expand_round_keys();
    logic [WORD_W-1:0] k;
    logic [WORD_W-1:0] l;
    k = key_lo;
    l = key_hi;
    round_keys[0] = k;
    for (int r = 0; r + 1 < ROUNDS && r < 31; r++) begin
      l = (rotr_byte(l) + k) ^ WORD_W'(r);
      k = rotl_three(k) ^ l;
      round_keys[r + 1] = k;
    end
    keys_stale = 1'b0;
  endfunction

  // Counter block: all zero but byte 15, which carries the block index (top of x)
  function automatic void encrypt_counter();
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    x = {blk_idx, {(WORD_W - IDX_W){1'b0}}};
    y = '0;
    for (int r = 0; r < ROUNDS && r < 32; r++) begin
      x = (rotr_byte(x) + y) ^ round_keys[r];
      y = rotl_three(y) ^ x;
    end
    ks_x = x;
    ks_y = y;
  endfunction

  // One accepted input word: returns its output word and advances position/index
  function automatic out_word_t xor_keystream(input logic [BYTE_W-1:0] d, input logic eom);
    out_word_t         w;
    logic [BYTE_W-1:0] ks;
    if (keys_stale) expand_round_keys();
    if (byte_pos == '0) encrypt_counter();
    if (byte_pos < 8) ks = ks_y[8 * byte_pos[2:0] +: 8];
    else ks = ks_x[8 * byte_pos[2:0] +: 8];
    w.data = d ^ ks;
    w.last = eom;
    byte_pos = byte_pos + 1'b1;
    if (byte_pos == '0) blk_idx = blk_idx + 1'b1;
    if (eom) begin
      byte_pos = '0;
      blk_idx  = '0;
    end
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t got;
    out_word_t want;
    if (!rst_ni) begin
      key_lo       = '0;
      key_hi       = '0;
      keys_stale   = 1'b1;
      ks_x         = '0;
      ks_y         = '0;
      byte_pos     = '0;
      blk_idx      = '0;
      shown        = 0;
      want_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[3] == REG_KEY_LOW) key_lo = pwdata_i;
        else key_hi = pwdata_i;
        keys_stale = 1'b1;
      end
      if (s_tvalid_i && s_tready_i) want_q.push_back(xor_keystream(s_tdata_i, s_tlast_i));
      if (m_tvalid_i && m_tready_i) begin
        got.data = m_tdata_i;
        got.last = m_tlast_i;
        if (want_q.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (shown < MAX_SHOWN)
            $display("%t: unexpected word: expected none, actual data %02h last %0b",
                     $realtime, got.data, got.last);
          shown++;
        end else begin
          want = want_q.pop_front();
          if (got.data !== want.data || got.last !== want.last) begin
            fail_count_o <= fail_count_o + 1;
            if (shown < MAX_SHOWN) begin
              if (got.data !== want.data)
                $display("%t: data_out mismatch: expected %02h, actual %02h",
                         $realtime, want.data, got.data);
              if (got.last !== want.last)
                $display("%t: final_byte mismatch: expected %0b, actual %0b",
                         $realtime, want.last, got.last);
            end else if (shown == MAX_SHOWN) begin
              $display("%t: further mismatches counted but not shown", $realtime);
            end
            shown++;
          end
        end
      end
      pending_o <= want_q.size();
    end
  end

endmodule
`default_nettype wire

### sim/speck128_ctr_keystream_xor_top_tb.sv
// Testbench top for the SPECK-128 CTR byte stream: stimulus, APB key writes and verdict.
`timescale 1ns / 100ps
`default_nettype none
module speck128_ctr_keystream_xor_top_tb;
  import spk_pkg::*;

  localparam int RANDOM_WORDS = 540;
  // Several full blocks plus a tail: the block index counts up across blocks
  localparam int LONG_MSG_LEN = 16 * 8 + 5;

  // DUT-facing signals; every input starts at a known value
  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic [7:0]  s_tdata  = '0;
  logic        s_tlast  = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [3:0]  paddr    = '0;
  logic [63:0] pwdata   = '0;
  logic [63:0] prdata;
  logic        pready;

  int fail_count;
  int pending;

  // Idle rates in percent; changed per phase
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  speck128_ctr_keystream_xor_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tlast_i (s_tlast),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tlast_o (m_tlast),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Checker sits beside the DUT and only watches the ports
  speck128_ctr_keystream_xor_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tdata_i   (s_tdata),
    .s_tlast_i   (s_tlast),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .m_tdata_i   (m_tdata),
    .m_tlast_i   (m_tlast),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .pready_i    (pready),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Output side back-pressure: one fresh decision per cycle
  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Entered right after a rising edge. Optional idle gap, then one word held
  // until the handshake edge. With no gap tvalid stays high into the next word.
  task automatic send_word(input logic [7:0] d, input logic last);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tdata  <= d;
    s_tlast  <= last;
    s_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_tready);
  endtask

  // One message of random bytes, end marker on the last one
  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send_word(8'($urandom), i == len - 1);
  endtask

  // Random messages, mostly short; the final one may be left open so that
  // position and index carry over into the next phase
  task automatic random_traffic(input int n_words);
    int len;
    while (n_words > 0) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(70, 17) : $urandom_range(20, 1);
      if (len > n_words) begin
        for (int i = 0; i < n_words; i++) send_word(8'($urandom), 1'b0);
        n_words = 0;
      end else begin
        send_message(len);
        n_words -= len;
      end
    end
  endtask

  // Stop sending and wait until every predicted word has come back. The extra
  // edge first lets the checker count a word accepted at the current edge.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write: setup cycle, access cycle, register taken at the edge with pready,
  // then back to idle before the next transfer
  task automatic write_key(input logic idx, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_keys(input logic [63:0] lo, input logic [63:0] hi);
    write_key(REG_KEY_LOW, lo);
    write_key(REG_KEY_HIGH, hi);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, reset keys (all zero) first
    send_word(8'h00, 1'b1);            // single-byte message at block 0
    send_word(8'hFF, 1'b1);
    // 18-byte message: crosses the block end, index 0 -> 1, then end of message
    for (int i = 0; i < 18; i++)
      send_word((i % 4 == 0) ? 8'h55 : (i % 4 == 1) ? 8'hAA :
                (i % 4 == 2) ? 8'h00 : 8'hFF, i == 17);
    // Key change in mid-message: position and index must survive the write
    send_word(8'h01, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h7F, 1'b0);
    drain();
    set_keys(64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
    send_word(8'hFE, 1'b0);
    send_word(8'h10, 1'b1);
    drain();

    // Phase 0: no idling; one long message runs through several counter blocks
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_keys(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_message(LONG_MSG_LEN);
    random_traffic(RANDOM_WORDS / 4);
    drain();

    // Phase 1: sender idle most cycles
    send_idle_pct  = 66;
    recv_stall_pct = 0;
    set_keys(64'h0, 64'h0);
    random_traffic(RANDOM_WORDS / 4);
    drain();

    // Phase 2: receiver stalls most cycles
    send_idle_pct  = 0;
    recv_stall_pct = 66;
    set_keys({$urandom, $urandom}, {$urandom, $urandom});
    random_traffic(RANDOM_WORDS / 4);
    drain();

    // Phase 3: both sides idle now and then
    send_idle_pct  = 23;
    recv_stall_pct = 23;
    set_keys(64'h1, 64'h8000_0000_0000_0000);
    random_traffic(RANDOM_WORDS / 8);
    drain();
    set_keys({$urandom, $urandom}, {$urandom, $urandom});
    random_traffic(RANDOM_WORDS / 8);

    // Everything sent: wait out the last results, then a short tail
    drain();
    repeat (60) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("speck128_ctr_keystream_xor_top regression: pass");
    end else begin
      $display("speck128_ctr_keystream_xor_top regression: fail");
    end
    $finish;
  end

  // Hang guard, far above the slowest legal run
  initial begin
    #20_000_000;
    $display("speck128_ctr_keystream_xor_top regression: fail");
    $finish;
  end

endmodule
`default_nettype wire
